// ----- sv/smra_pkg.sv -----
`timescale 1ns / 1ps
package smra_pkg;

    localparam int MATRIX_DIM_DEF    = 4;
    localparam int MATRIX_COUNT_DEF  = 6;
    localparam int ELEMENT_BITS_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_SCALE = 3'd4,
        OP_TRANS = 3'd5,
        OP_READ  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_MUL,
        ST_OUT,
        ST_COPY_RD,
        ST_COPY_WR
    } t_state;

endpackage

// ----- sv/smra_mem.sv -----
`timescale 1ns / 1ps
module smra_mem import smra_pkg::*; #(
    parameter int DEPTH = MATRIX_COUNT_DEF * MATRIX_DIM_DEF * MATRIX_DIM_DEF,
    parameter int WIDTH = ELEMENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_ram [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // entry not yet written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ram[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_vld[i_rd_addr_a] ? r_ram[i_rd_addr_a] : '0;
        r_rd_b <= r_vld[i_rd_addr_b] ? r_ram[i_rd_addr_b] : '0;
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- sv/smra_mul.sv -----
`timescale 1ns / 1ps
module smra_mul import smra_pkg::*; #(
    parameter int EW = ELEMENT_BITS_DEF,
    parameter int FB = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [EW-1:0] i_a,
    input  logic signed [EW-1:0] i_b,
    output logic                 o_done,
    output logic signed [EW-1:0] o_result
);

    localparam int DB    = 4;
    localparam int NSTEP = (EW + DB - 1) / DB;
    localparam int UW    = NSTEP * DB;
    localparam int AW2   = 2 * UW;
    localparam int PW    = 2 * EW + 1;
    localparam int SW    = $clog2(NSTEP);
    localparam logic signed [PW-1:0] EL_MAX_W = $signed((PW'(1) << (EW - 1)) - PW'(1));
    localparam logic signed [PW-1:0] EL_MIN_W = -EL_MAX_W - PW'(1);

    logic                 r_busy, r_fin, r_done, r_neg;
    logic [SW-1:0]        r_step;
    logic [AW2-1:0]       r_ua, r_acc;
    logic [UW-1:0]        r_ub;
    logic signed [EW-1:0] r_res;

    logic [EW-1:0]        a_mag, b_mag;
    logic signed [PW-1:0] prod_s, prod_sh;
    logic signed [EW-1:0] res_sat;

    // magnitudes, the most negative value maps to its unsigned size
    assign a_mag = i_a[EW-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag = i_b[EW-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        prod_s  = r_neg ? -$signed({1'b0, r_acc[2*EW-1:0]}) : $signed({1'b0, r_acc[2*EW-1:0]});
        prod_sh = prod_s >>> FB;
        if (prod_sh > EL_MAX_W) begin
            res_sat = EL_MAX_W[EW-1:0];
        end else if (prod_sh < EL_MIN_W) begin
            res_sat = EL_MIN_W[EW-1:0];
        end else begin
            res_sat = prod_sh[EW-1:0];
        end
    end

    // one 4-bit digit of the multiplier per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == SW'(NSTEP - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua   <= AW2'(a_mag);
            r_ub   <= UW'(b_mag);
            r_neg  <= i_a[EW-1] ^ i_b[EW-1];
            r_acc  <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_acc  <= r_acc + r_ua * r_ub[DB-1:0];
            r_ua   <= r_ua << DB;
            r_ub   <= r_ub >> DB;
            r_step <= r_step + 1'b1;
        end
        if (r_fin) begin
            r_res <= res_sat;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- sv/small_matrix_register_alu_top.sv -----
`timescale 1ns / 1ps
// the multiplier works in N = ceil(ELEMENT_BITS/4) digit steps (8 by default);
//   write element is done from idle; add, subtract, transpose and scale go element by element;
//   multiply does one multiply-accumulate per inner index; results are staged, then copied back;
//   read out gives one result item at a time and holds it while the output is stalled
// one item at a time, set by the shared digit-serial multiplier and the single store
// reset: synchronous active low, all matrices read as zero, block idle, no item pending
module small_matrix_register_alu_top import smra_pkg::*; #(
    parameter int MATRIX_DIM    = MATRIX_DIM_DEF,
    parameter int MATRIX_COUNT  = MATRIX_COUNT_DEF,
    parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic [2:0]         i_first_source,
    input  logic [2:0]         i_second_source,
    input  logic [2:0]         i_destination,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_operand_value,
    // result item channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_element_value,
    output logic [1:0]         o_row_number,
    output logic [1:0]         o_column_number,
    output logic               o_is_last
);

    localparam int EW    = ELEMENT_BITS;
    localparam int D     = MATRIX_DIM;
    localparam int CELLS = D * D;
    localparam int DW    = $clog2(D);
    localparam int PAW   = $clog2(CELLS);
    localparam int DEPTH = MATRIX_COUNT * CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(CELLS + 1) + 4;
    localparam logic signed [64:0] EL_MAX_L = $signed((65'(1) << (EW - 1)) - 65'(1));
    localparam logic signed [64:0] EL_MIN_L = -EL_MAX_L - 65'sd1;
    localparam logic signed [64:0] OUT_MAX  = 65'sd2147483647;
    localparam logic signed [64:0] OUT_MIN  = -65'sd2147483648;

    // saturate a wide value to the element range
    function automatic logic signed [EW-1:0] clamp_el(input logic signed [64:0] v);
        logic signed [64:0] c;
        c = v;
        if (v > EL_MAX_L) begin
            c = EL_MAX_L;
        end else if (v < EL_MIN_L) begin
            c = EL_MIN_L;
        end
        return c[EW-1:0];
    endfunction

    function automatic logic [AW-1:0] mat_base(input logic [2:0] mat);
        return AW'(AW'(mat) * AW'(CELLS));
    endfunction

    // sequencer state
    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [2:0]           r_xs, n_xs, r_ys, n_ys, r_zs, n_zs;
    logic signed [EW-1:0] r_val, n_val;
    logic [DW-1:0]        r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [EW-1:0] r_acc, n_acc;

    // staging buffer so that a destination may also be a source
    logic signed [EW-1:0] r_tmp [CELLS];
    logic signed [EW-1:0] r_tmp_q;
    logic                 tmp_we;
    logic signed [EW-1:0] tmp_data;

    // output register
    logic                 r_o_valid, n_o_valid;
    logic signed [31:0]   r_o_value, n_o_value;
    logic [1:0]           r_o_row, n_o_row, r_o_col, n_o_col;
    logic                 r_o_last, n_o_last;

    // store and multiplier hookup
    logic                 wr_en;
    logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    logic [EW-1:0]        wr_data, rd_a_raw, rd_b_raw;
    logic signed [EW-1:0] rd_a, rd_b;
    logic                 mul_start, mul_done;
    logic signed [EW-1:0] mul_b, mul_res;

    // element offsets for the current row, column and inner index
    logic [PAW-1:0]       off_ij, off_ji, off_ik, off_kj;
    logic                 j_end, last_ij, k_end;
    logic [DW-1:0]        i_nx, j_nx;
    logic signed [EW-1:0] add_res, sub_res, mac_res, in_val;
    logic signed [64:0]   rd_a_w;
    logic signed [31:0]   rd_a_sat;
    logic                 ok_x, ok_y, ok_z, ok_idx;
    t_op                  in_op;

    assign off_ij = PAW'(PAW'(r_i) * PAW'(D) + PAW'(r_j));
    assign off_ji = PAW'(PAW'(r_j) * PAW'(D) + PAW'(r_i));
    assign off_ik = PAW'(PAW'(r_i) * PAW'(D) + PAW'(r_k));
    assign off_kj = PAW'(PAW'(r_k) * PAW'(D) + PAW'(r_j));

    assign j_end   = (r_j == DW'(D - 1));
    assign last_ij = j_end && (r_i == DW'(D - 1));
    assign k_end   = (r_k == DW'(D - 1));
    assign j_nx    = j_end ? '0 : r_j + 1'b1;
    assign i_nx    = j_end ? r_i + 1'b1 : r_i;

    assign rd_a = rd_a_raw;
    assign rd_b = rd_b_raw;

    // saturating element arithmetic
    assign add_res = clamp_el(65'(rd_a) + 65'(rd_b));
    assign sub_res = clamp_el(65'(rd_a) - 65'(rd_b));
    assign mac_res = clamp_el(65'(r_acc) + 65'(mul_res));
    assign in_val  = clamp_el(65'(i_operand_value));

    assign rd_a_w   = 65'(rd_a);
    assign rd_a_sat = (rd_a_w > OUT_MAX) ? 32'sh7fffffff :
                      (rd_a_w < OUT_MIN) ? 32'sh80000000 : rd_a_w[31:0];

    // operand checks on the incoming item
    assign in_op  = t_op'(i_operation);
    assign ok_x   = ({1'b0, i_first_source} < 4'(MATRIX_COUNT));
    assign ok_y   = ({1'b0, i_second_source} < 4'(MATRIX_COUNT));
    assign ok_z   = ({1'b0, i_destination} < 4'(MATRIX_COUNT));
    assign ok_idx = (CW'(i_element_index) < CW'(CELLS));

    // read addresses follow the operation's access pattern
    always_comb begin
        case (r_op)
            OP_MUL: begin
                rd_addr_a = AW'(mat_base(r_xs) + AW'(off_ik));
                rd_addr_b = AW'(mat_base(r_ys) + AW'(off_kj));
            end
            OP_TRANS: begin
                rd_addr_a = AW'(mat_base(r_xs) + AW'(off_ji));
                rd_addr_b = AW'(mat_base(r_xs) + AW'(off_ji));
            end
            OP_ADD, OP_SUB: begin
                rd_addr_a = AW'(mat_base(r_xs) + AW'(off_ij));
                rd_addr_b = AW'(mat_base(r_ys) + AW'(off_ij));
            end
            default: begin
                rd_addr_a = AW'(mat_base(r_xs) + AW'(off_ij));
                rd_addr_b = AW'(mat_base(r_xs) + AW'(off_ij));
            end
        endcase
    end

    assign mul_b = (r_op == OP_MUL) ? rd_b : r_val;

    // sequencer: one element step, or one multiply-accumulate, per pass
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_xs      = r_xs;
        n_ys      = r_ys;
        n_zs      = r_zs;
        n_val     = r_val;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_acc     = r_acc;
        n_o_valid = r_o_valid;
        n_o_value = r_o_value;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_last  = r_o_last;
        wr_en     = 1'b0;
        wr_addr   = AW'(mat_base(r_zs) + AW'(off_ij));
        wr_data   = r_tmp_q;
        mul_start = 1'b0;
        tmp_we    = 1'b0;
        tmp_data  = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op  = in_op;
                    n_xs  = i_first_source;
                    n_ys  = i_second_source;
                    n_zs  = i_destination;
                    n_val = in_val;
                    n_i   = '0;
                    n_j   = '0;
                    n_k   = '0;
                    n_acc = '0;
                    case (in_op)
                        OP_WRITE: begin
                            if (ok_x && ok_idx) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(mat_base(i_first_source)
                                              + AW'(PAW'(i_element_index)));
                                wr_data = in_val;
                            end
                        end
                        OP_READ: begin
                            if (ok_x) begin
                                n_state = ST_FETCH;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL: begin
                            if (ok_x && ok_y && ok_z) begin
                                n_state = ST_FETCH;
                            end
                        end
                        OP_SCALE, OP_TRANS: begin
                            if (ok_x && ok_z) begin
                                n_state = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                case (r_op)
                    OP_ADD, OP_SUB, OP_TRANS: begin
                        tmp_we   = 1'b1;
                        tmp_data = (r_op == OP_ADD) ? add_res :
                                   (r_op == OP_SUB) ? sub_res : rd_a;
                        if (last_ij) begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_COPY_RD;
                        end else begin
                            n_i     = i_nx;
                            n_j     = j_nx;
                            n_state = ST_FETCH;
                        end
                    end
                    OP_SCALE, OP_MUL: begin
                        mul_start = 1'b1;
                        n_state   = ST_MUL;
                    end
                    OP_READ: begin
                        n_o_valid = 1'b1;
                        n_o_value = rd_a_sat;
                        n_o_row   = 2'(r_i);
                        n_o_col   = 2'(r_j);
                        n_o_last  = last_ij;
                        n_state   = ST_OUT;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MUL: begin
                if (mul_done) begin
                    if (r_op == OP_SCALE || k_end) begin
                        tmp_we   = 1'b1;
                        tmp_data = (r_op == OP_SCALE) ? mul_res : mac_res;
                        n_acc    = '0;
                        n_k      = '0;
                        if (last_ij) begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_COPY_RD;
                        end else begin
                            n_i     = i_nx;
                            n_j     = j_nx;
                            n_state = ST_FETCH;
                        end
                    end else begin
                        n_acc   = mac_res;
                        n_k     = r_k + 1'b1;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = i_nx;
                        n_j     = j_nx;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_COPY_RD: begin
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                wr_en = 1'b1;
                if (last_ij) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_i     = i_nx;
                    n_j     = j_nx;
                    n_state = ST_COPY_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_xs      <= n_xs;
        r_ys      <= n_ys;
        r_zs      <= n_zs;
        r_val     <= n_val;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_acc     <= n_acc;
        r_o_value <= n_o_value;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_last  <= n_o_last;
    end

    // staging buffer, read one entry at a time in the copy read state during the copy
    always_ff @(posedge i_clk) begin
        if (tmp_we) begin
            r_tmp[off_ij] <= tmp_data;
        end
        if (r_state == ST_COPY_RD) begin
            r_tmp_q <= r_tmp[off_ij];
        end
    end

    smra_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a_raw),
        .o_rd_data_b (rd_b_raw)
    );

    smra_mul #(
        .EW (EW),
        .FB (FRACTION_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (rd_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_o_valid;
    assign o_element_value = r_o_value;
    assign o_row_number    = r_o_row;
    assign o_column_number = r_o_col;
    assign o_is_last       = r_o_last;

    // a pending result item always keeps the input side closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while input open");

    // results only come from the readout output state
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_OUT))
        else $error("result valid outside readout");

    // the last flag marks the bottom-right element
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> (r_i == DW'(D - 1) && r_j == DW'(D - 1)))
        else $error("last flag on wrong element");

    // multiplier finishes only while the sequencer waits for it
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MUL))
        else $error("multiplier done out of sequence");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import smra_pkg::*;

    // codes that the package leaves out: the unused operation and two absent matrix numbers
    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam logic [2:0] NO_MATRIX   = 3'd7;
    localparam logic [2:0] PAST_MATRIX = 3'd6;
    localparam int DIM    = 4;
    localparam int CELLS  = DIM * DIM;
    localparam int COUNT  = 6;
    localparam int FRAC   = 16;
    // slowest item is a multiply
    localparam int SETTLE_CYCLES = 1000;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam longint EL_MAX = 64'sd2147483647;
    localparam longint EL_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         row;
        logic [1:0]         column;
        logic               last;
    } t_element;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_operation = '0;
    logic [2:0]         i_first_source = '0;
    logic [2:0]         i_second_source = '0;
    logic [2:0]         i_destination = '0;
    logic [3:0]         i_element_index = '0;
    logic signed [31:0] i_operand_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_element_value;
    logic [1:0]         o_row_number;
    logic [1:0]         o_column_number;
    logic               o_is_last;

    small_matrix_register_alu_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_first_source  (i_first_source),
        .i_second_source (i_second_source),
        .i_destination   (i_destination),
        .i_element_index (i_element_index),
        .i_operand_value (i_operand_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_element_value (o_element_value),
        .o_row_number    (o_row_number),
        .o_column_number (o_column_number),
        .o_is_last       (o_is_last)
    );

    // shadow copy of the matrix bank and the readout elements still to come
    longint   shadow_bank [COUNT*CELLS];
    t_element readout_queue [$];
    int       error_count = 0;
    int       items_sent = 0;
    int       elements_seen = 0;
    int       burst_left = 0;
    longint   cycle_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall: switches between no stall, light, heavy and periodic stalling
    int stall_mode = 0;
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (stall_phase % 5 < 2);
        endcase
    end

    function automatic longint clamp_element(longint v);
        if (v > EL_MAX) return EL_MAX;
        if (v < EL_MIN) return EL_MIN;
        return v;
    endfunction

    // exact product, arithmetic shift drops the fraction, then saturate
    function automatic longint fixed_product(longint a, longint b);
        longint p;
        p = a * b;
        return clamp_element(p >>> FRAC);
    endfunction

    // apply one accepted item to the shadow bank, queue any readout elements
    task automatic apply_item(logic [2:0] op, logic [2:0] xs, logic [2:0] ys,
                              logic [2:0] zs, logic [3:0] idx, logic signed [31:0] val);
        longint   result [CELLS];
        longint   acc;
        t_element e;
        int       p;
        if (op == OP_UNUSED || xs >= COUNT) return;
        if (op == OP_WRITE) begin
            shadow_bank[xs*CELLS + idx] = longint'(val);
            return;
        end
        if (op == OP_READ) begin
            for (int n = 0; n < CELLS; n++) begin
                e.value  = 32'(shadow_bank[xs*CELLS + n]);
                e.row    = 2'(n / DIM);
                e.column = 2'(n % DIM);
                e.last   = (n == CELLS - 1);
                readout_queue.push_back(e);
            end
            return;
        end
        if (zs >= COUNT) return;
        if ((op == OP_ADD || op == OP_SUB || op == OP_MUL) && ys >= COUNT) return;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                p = i*DIM + j;
                acc = 0;
                case (op)
                    OP_ADD: acc = clamp_element(shadow_bank[xs*CELLS+p]
                                                + shadow_bank[ys*CELLS+p]);
                    OP_SUB: acc = clamp_element(shadow_bank[xs*CELLS+p]
                                                - shadow_bank[ys*CELLS+p]);
                    OP_MUL: begin
                        // running sum saturates at each step, k ascending
                        for (int k = 0; k < DIM; k++)
                            acc = clamp_element(acc + fixed_product(
                                shadow_bank[xs*CELLS + i*DIM + k],
                                shadow_bank[ys*CELLS + k*DIM + j]));
                    end
                    OP_SCALE: acc = fixed_product(shadow_bank[xs*CELLS+p], longint'(val));
                    default: acc = shadow_bank[xs*CELLS + j*DIM + i];
                endcase
                result[p] = acc;
            end
        end
        // sources are fully read before the destination changes
        for (int n = 0; n < CELLS; n++)
            shadow_bank[zs*CELLS + n] = result[n];
    endtask

    // one item: random burst gaps in front, held until accepted
    task automatic send_item(logic [2:0] op, logic [2:0] xs, logic [2:0] ys,
                             logic [2:0] zs, logic [3:0] idx, logic signed [31:0] val);
        logic stalled;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_first_source  <= xs;
        i_second_source <= ys;
        i_destination   <= zs;
        i_element_index <= idx;
        i_operand_value <= val;
        // stall is sampled mid-cycle so the accepting edge is the one it covers
        forever begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
            if (!stalled) break;
        end
        apply_item(op, xs, ys, zs, idx, val);
        items_sent++;
    endtask

    // hold off the sender until every readout element is back and the block settles
    task automatic drain_block();
        i_valid <= 1'b0;
        burst_left = 0;
        while (readout_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_element want;
        if (i_rst_n && o_valid && !i_stall) begin
            elements_seen++;
            if (readout_queue.size() == 0) begin
                $error("unexpected element %0d", o_element_value);
                error_count++;
            end else begin
                want = readout_queue.pop_front();
                if (o_element_value !== want.value) begin
                    $error("element_value expected %0d got %0d", want.value, o_element_value);
                    error_count++;
                end
                if (o_row_number !== want.row) begin
                    $error("row_number expected %0d got %0d", want.row, o_row_number);
                    error_count++;
                end
                if (o_column_number !== want.column) begin
                    $error("column_number expected %0d got %0d", want.column, o_column_number);
                    error_count++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last expected %0d got %0d", want.last, o_is_last);
                    error_count++;
                end
            end
        end
    end

    // small Q15.16 numbers, mixed with extremes, zero and raw bit patterns
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(0);
            3, 4: return $signed($urandom());
            default: return ($signed(32'($urandom_range(0, 8))) - 4) * 65536
                            + $signed(32'($urandom_range(0, 65535)));
        endcase
    endfunction

    function automatic logic [2:0] pick_matrix();
        return 3'($urandom_range(0, COUNT - 1));
    endfunction

    // extremes written, read back from a cleared bank
    task automatic test_write_extremes();
        send_item(OP_READ, 3'd5, 3'd0, 3'd0, 4'd0, 0);
        send_item(OP_WRITE, 3'd0, 3'd0, 3'd0, 4'd0, 32'sh7fffffff);
        send_item(OP_WRITE, 3'd0, 3'd0, 3'd0, 4'd15, 32'sh80000000);
        send_item(OP_WRITE, 3'd0, 3'd0, 3'd0, 4'd5, 32'sh00010000);
        send_item(OP_WRITE, 3'd1, 3'd0, 3'd0, 4'd0, 32'sh7fffffff);
        send_item(OP_WRITE, 3'd1, 3'd0, 3'd0, 4'd15, 32'sh7fffffff);
        send_item(OP_READ, 3'd0, 3'd0, 3'd0, 4'd0, 0);
    endtask

    // add and subtract hitting both saturation limits, in place too
    task automatic test_add_sub();
        send_item(OP_ADD, 3'd0, 3'd1, 3'd2, 4'd0, 0);
        send_item(OP_SUB, 3'd0, 3'd1, 3'd3, 4'd0, 0);
        send_item(OP_SUB, 3'd3, 3'd3, 3'd3, 4'd0, 0);
        send_item(OP_READ, 3'd2, 3'd0, 3'd0, 4'd0, 0);
    endtask

    // multiply, scale and transpose, destination equal to a source
    task automatic test_mul_scale_trans();
        send_item(OP_MUL, 3'd0, 3'd1, 3'd4, 4'd0, 0);
        send_item(OP_SCALE, 3'd0, 3'd0, 3'd5, 4'd0, 32'sh80000000);
        send_item(OP_TRANS, 3'd0, 3'd0, 3'd0, 4'd0, 0);
        send_item(OP_MUL, 3'd0, 3'd0, 3'd0, 4'd0, 0);
        send_item(OP_READ, 3'd4, 3'd0, 3'd0, 4'd0, 0);
        send_item(OP_READ, 3'd0, 3'd0, 3'd0, 4'd0, 0);
    endtask

    // unused operation and out-of-range matrix numbers must change nothing
    task automatic test_ignored();
        send_item(OP_UNUSED, 3'd0, 3'd0, 3'd0, 4'd0, 32'sh12345678);
        send_item(OP_WRITE, NO_MATRIX, 3'd0, 3'd0, 4'd3, 32'sh11111111);
        send_item(OP_READ, PAST_MATRIX, 3'd0, 3'd0, 4'd0, 0);
        send_item(OP_ADD, 3'd0, NO_MATRIX, 3'd1, 4'd0, 0);
        send_item(OP_SCALE, 3'd0, 3'd0, NO_MATRIX, 4'd0, 32'sh00020000);
        send_item(OP_READ, 3'd1, 3'd0, 3'd0, 4'd0, 0);
    endtask

    // sequences: fill some elements, run an operation, often read the result back
    task automatic test_random_sequences(int item_budget);
        logic [2:0] op, dst;
        int start;
        start = items_sent;
        while (items_sent - start < item_budget) begin
            repeat ($urandom_range(1, 5))
                send_item(OP_WRITE, pick_matrix(), 3'($urandom()), 3'($urandom()),
                          4'($urandom()), pick_value());
            op  = 3'($urandom_range(OP_ADD, OP_TRANS));
            dst = pick_matrix();
            send_item(op, pick_matrix(), pick_matrix(), dst, 4'($urandom()), pick_value());
            if ($urandom_range(0, 9) == 0)
                // noise: any code, any matrix number
                send_item(3'($urandom()), 3'($urandom()), 3'($urandom()),
                          3'($urandom()), 4'($urandom()), $signed($urandom()));
            if ($urandom_range(0, 2) != 0)
                send_item(OP_READ, dst, 3'($urandom()), 3'($urandom()),
                          4'($urandom()), $signed($urandom()));
            if ($urandom_range(0, 24) == 0)
                drain_block();
        end
    endtask

    initial begin
        for (int n = 0; n < COUNT*CELLS; n++)
            shadow_bank[n] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_write_extremes();
        test_add_sub();
        test_mul_scale_trans();
        drain_block();
        test_ignored();
        test_random_sequences(210);
        drain_block();
        $display("covered %0d items across all operations, ignored codes and saturation",
                 items_sent);
        $display("checked %0d readout elements", elements_seen);
        if (error_count == 0 && readout_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- small_matrix_register_alu_top.f -----
sv/smra_pkg.sv
sv/smra_mem.sv
sv/smra_mul.sv
sv/small_matrix_register_alu_top.sv
tb/sv/testbench.sv
